// File: design/apd_pkg.sv
// adc pulse detector package: widths, limits, phase and register codes
// used by the channel interfaces and the top level
// no dependencies

package apd_pkg;

    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned COUNT_W     = 12;
    localparam int unsigned SQ_W        = 2 * SAMPLE_W;
    localparam int unsigned WINDOW_W    = 8;
    localparam int unsigned QUIET_W     = 16;
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned ARM_KEPT    = 3;

    localparam logic [COUNT_W-1:0] MAX_CAPTURE = 12'd3000;
    localparam logic [COUNT_W-1:0] ARM_COUNT   = 12'd4;

    // square sum rescale: x / 10000 = (x >> 4) / 625, x < 2^27 when reachable
    localparam logic [SUM_W-1:0]   SQ_LIMIT    = 32'd100000;
    localparam logic [SUM_W-1:0]   SQ_BOUND    = 32'h0800_0000;
    localparam int unsigned        DIV_LO      = 4;
    localparam int unsigned        DIV_HI      = 26;
    localparam int unsigned        RECIP_W     = 23;
    localparam int unsigned        PROD_W      = 2 * RECIP_W;
    localparam int unsigned        QUOT_LO     = 32;
    localparam int unsigned        QUOT_W      = PROD_W - QUOT_LO;
    localparam logic [RECIP_W-1:0] RECIP_625   = 23'd6871948;

    localparam logic [SAMPLE_W-1:0] RST_BASELINE = 12'd0;
    localparam logic [SAMPLE_W-1:0] RST_GAP      = 12'd55;
    localparam logic [WINDOW_W-1:0] RST_WINDOW   = 8'd10;
    localparam logic [QUIET_W-1:0]  RST_QUIET    = 16'd1000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ARM1,
        PH_ARM2,
        PH_ARM3,
        PH_CAPTURE
    } t_phase;

    typedef enum logic [1:0] {
        REG_BASELINE,
        REG_GAP,
        REG_WINDOW,
        REG_QUIET
    } t_reg_idx;

endpackage

// File: design/apd_sample_if.sv
// sample channel: valid/ready handshake with one adc sample and its timestamp
// depends on apd_pkg

interface apd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [apd_pkg::SAMPLE_W-1:0]  sample;
    logic [apd_pkg::TIME_W-1:0]    timestamp;

    modport source (output valid, output sample, output timestamp, input ready);
    modport sink   (input valid, input sample, input timestamp, output ready);
endinterface

// File: design/apd_result_if.sv
// result channel: valid/ready handshake with one pulse summary per beat
// depends on apd_pkg

interface apd_result_if;
    logic                          valid;
    logic                          ready;
    logic [apd_pkg::TIME_W-1:0]    duration;
    logic [apd_pkg::SUM_W-1:0]     level_sum;
    logic [apd_pkg::SUM_W-1:0]     square_sum;
    logic [apd_pkg::SAMPLE_W-1:0]  peak_level;
    logic [apd_pkg::TIME_W-1:0]    peak_time;
    logic [apd_pkg::COUNT_W-1:0]   sample_count;

    modport source (output valid, output duration, output level_sum, output square_sum,
                    output peak_level, output peak_time, output sample_count,
                    input ready);
    modport sink   (input valid, input duration, input level_sum, input square_sum,
                    input peak_level, input peak_time, input sample_count,
                    output ready);
endinterface

// File: design/adc_pulse_detector.sv
// adc pulse detector top level: arming, capture accumulation, apb registers
// an ending sample passes the input and square stages; o_result.valid comes from a register
// throughput: one sample beat per cycle; the square stage and the state stage
// stall only while an ending sample meets a result still waiting in the output register
// reset: synchronous, active low; clears control state, sums, peak and registers
// depends on apd_pkg, apd_sample_if, apd_result_if

module adc_pulse_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    apd_sample_if.sink                   i_sample,
    apd_result_if.source                 o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apd_pkg::PADDR_W-1:0]  paddr,
    input  logic [apd_pkg::PDATA_W-1:0]  pwdata,
    output logic [apd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    // config registers
    logic [apd_pkg::SAMPLE_W-1:0] r_baseline;
    logic [apd_pkg::SAMPLE_W-1:0] r_gap;
    logic [apd_pkg::WINDOW_W-1:0] r_window;
    logic [apd_pkg::QUIET_W-1:0]  r_quiet;
    apd_pkg::t_reg_idx            w_reg_idx;

    // pipeline stages
    logic                         r_v1;
    logic [apd_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [apd_pkg::TIME_W-1:0]   r_s1_time;
    logic                         r_v2;
    logic [apd_pkg::SAMPLE_W-1:0] r_s2_sample;
    logic [apd_pkg::TIME_W-1:0]   r_s2_time;
    logic [apd_pkg::SQ_W-1:0]     r_s2_sq;

    // detector state
    apd_pkg::t_phase              r_phase;
    apd_pkg::t_phase              n_phase;
    logic [apd_pkg::SAMPLE_W-1:0] r_arm_sample [apd_pkg::ARM_KEPT];
    logic [apd_pkg::TIME_W-1:0]   r_arm_time   [apd_pkg::ARM_KEPT];
    logic [apd_pkg::SQ_W-1:0]     r_arm_sq     [apd_pkg::ARM_KEPT];
    logic [apd_pkg::SUM_W-1:0]    r_sum,       n_sum;
    logic [apd_pkg::SUM_W-1:0]    r_sqsum,     n_sqsum;
    logic [apd_pkg::SAMPLE_W-1:0] r_peak,      n_peak;
    logic [apd_pkg::TIME_W-1:0]   r_peak_time, n_peak_time;
    logic [apd_pkg::TIME_W-1:0]   r_last,      n_last;
    logic [apd_pkg::TIME_W-1:0]   r_start,     n_start;
    logic [apd_pkg::COUNT_W-1:0]  r_count,     n_count;

    // output register
    logic                         r_out_valid;
    logic [apd_pkg::TIME_W-1:0]   r_out_duration;
    logic [apd_pkg::SUM_W-1:0]    r_out_sum;
    logic [apd_pkg::SUM_W-1:0]    r_out_sqsum;
    logic [apd_pkg::SAMPLE_W-1:0] r_out_peak;
    logic [apd_pkg::TIME_W-1:0]   r_out_peak_time;
    logic [apd_pkg::COUNT_W-1:0]  r_out_count;

    // stage control
    logic                         w_emit;
    logic                         w_arm_we;
    logic [1:0]                   w_arm_idx;
    logic                         w_s2_fire;
    logic                         w_s2_load;
    logic                         w_s1_move;
    logic                         w_s1_load;
    logic                         w_cfg_we;

    // square sum rescale
    logic [apd_pkg::SUM_W-1:0]    w_sq_acc;
    logic [apd_pkg::PROD_W-1:0]   w_sq_prod;
    logic [apd_pkg::SUM_W-1:0]    w_sq_scaled;

    // ---------------- apb port ----------------
    assign pready    = 1'b1;
    assign w_cfg_we  = psel && penable && pwrite;
    assign w_reg_idx = apd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= apd_pkg::RST_BASELINE;
            r_gap      <= apd_pkg::RST_GAP;
            r_window   <= apd_pkg::RST_WINDOW;
            r_quiet    <= apd_pkg::RST_QUIET;
        end else if (w_cfg_we) begin
            case (w_reg_idx)
                apd_pkg::REG_BASELINE: r_baseline <= pwdata[apd_pkg::SAMPLE_W-1:0];
                apd_pkg::REG_GAP:      r_gap      <= pwdata[apd_pkg::SAMPLE_W-1:0];
                apd_pkg::REG_WINDOW:   r_window   <= pwdata[apd_pkg::WINDOW_W-1:0];
                apd_pkg::REG_QUIET:    r_quiet    <= pwdata[apd_pkg::QUIET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            apd_pkg::REG_BASELINE: prdata = {20'd0, r_baseline};
            apd_pkg::REG_GAP:      prdata = {20'd0, r_gap};
            apd_pkg::REG_WINDOW:   prdata = {24'd0, r_window};
            apd_pkg::REG_QUIET:    prdata = {16'd0, r_quiet};
            default:               prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign w_s2_fire = r_v2 && !(w_emit && r_out_valid && !o_result.ready);
    assign w_s2_load = !r_v2 || w_s2_fire;
    assign w_s1_move = r_v1 && w_s2_load;
    assign w_s1_load = !r_v1 || w_s1_move;
    assign i_sample.ready = w_s1_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_s1_load) begin
            r_v1 <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_sample.valid) begin
            r_s1_sample <= i_sample.sample;
            r_s1_time   <= i_sample.timestamp;
        end
    end

    // square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_s2_load) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_s2_sample <= r_s1_sample;
            r_s2_time   <= r_s1_time;
            r_s2_sq     <= {12'd0, r_s1_sample} * {12'd0, r_s1_sample};
        end
    end

    // ---------------- capture arithmetic ----------------
    assign w_sq_acc  = r_sqsum + {8'd0, r_s2_sq};
    assign w_sq_prod = {23'd0, w_sq_acc[apd_pkg::DIV_HI:apd_pkg::DIV_LO]}
                     * {23'd0, apd_pkg::RECIP_625};
    assign w_sq_scaled = (w_sq_acc > apd_pkg::SQ_LIMIT)
        ? {18'd0, w_sq_prod[apd_pkg::PROD_W-1:apd_pkg::QUOT_LO]}
        : w_sq_acc;

    // ---------------- next state ----------------
    always_comb begin
        logic [apd_pkg::SAMPLE_W-1:0] dev;
        logic [apd_pkg::TIME_W-1:0]   d_last;
        logic [apd_pkg::TIME_W-1:0]   d_first;
        logic [apd_pkg::TIME_W-1:0]   d_second;
        logic [apd_pkg::SAMPLE_W-1:0] best_s;
        logic [apd_pkg::TIME_W-1:0]   best_t;

        n_phase     = r_phase;
        n_sum       = r_sum;
        n_sqsum     = r_sqsum;
        n_peak      = r_peak;
        n_peak_time = r_peak_time;
        n_last      = r_last;
        n_start     = r_start;
        n_count     = r_count;
        w_emit      = 1'b0;
        w_arm_we    = 1'b0;
        w_arm_idx   = 2'd0;

        dev      = (r_s2_sample > r_baseline) ? r_s2_sample - r_baseline
                                              : r_baseline - r_s2_sample;
        d_last   = r_s2_time - r_last;
        d_first  = r_s2_time - r_arm_time[0];
        d_second = r_s2_time - r_arm_time[1];

        // latest equal maximum wins among arming samples
        best_s = r_s2_sample;
        best_t = r_s2_time;
        if (r_arm_sample[2] > best_s) begin
            best_s = r_arm_sample[2];
            best_t = r_arm_time[2];
        end
        if (r_arm_sample[1] > best_s) begin
            best_s = r_arm_sample[1];
            best_t = r_arm_time[1];
        end
        if (r_arm_sample[0] > best_s) begin
            best_s = r_arm_sample[0];
            best_t = r_arm_time[0];
        end

        if (r_phase == apd_pkg::PH_CAPTURE) begin
            if (r_s2_sample < r_gap && d_last > {16'd0, r_quiet}) begin
                w_emit  = 1'b1;
                n_phase = apd_pkg::PH_IDLE;
                n_sum   = '0;
                n_sqsum = '0;
            end else begin
                if (r_s2_sample > r_gap) begin
                    n_last = r_s2_time;
                end
                n_sum   = r_sum + {20'd0, r_s2_sample};
                n_sqsum = w_sq_scaled;
                if (r_s2_sample > r_peak) begin
                    n_peak      = r_s2_sample;
                    n_peak_time = r_s2_time;
                end
                if (r_count < apd_pkg::MAX_CAPTURE) begin
                    n_count = r_count + 1'b1;
                end
            end
        end else if (dev > r_gap) begin
            case (r_phase)
                apd_pkg::PH_IDLE: begin
                    w_arm_we = 1'b1;
                    n_phase  = apd_pkg::PH_ARM1;
                end
                apd_pkg::PH_ARM1, apd_pkg::PH_ARM2: begin
                    w_arm_we = 1'b1;
                    if (d_first < {24'd0, r_window}) begin
                        w_arm_idx = r_phase[1:0];
                        n_phase   = apd_pkg::t_phase'(r_phase + 3'd1);
                    end else begin
                        n_phase   = apd_pkg::PH_ARM1;
                    end
                end
                apd_pkg::PH_ARM3: begin
                    if (d_second < {24'd0, r_window}) begin
                        n_phase     = apd_pkg::PH_CAPTURE;
                        n_sum       = {20'd0, r_arm_sample[0]} + {20'd0, r_arm_sample[1]}
                                    + {20'd0, r_arm_sample[2]} + {20'd0, r_s2_sample};
                        n_sqsum     = {8'd0, r_arm_sq[0]} + {8'd0, r_arm_sq[1]}
                                    + {8'd0, r_arm_sq[2]} + {8'd0, r_s2_sq};
                        n_peak      = best_s;
                        n_peak_time = best_t;
                        n_start     = r_s2_time;
                        n_last      = r_s2_time;
                        n_count     = apd_pkg::ARM_COUNT;
                    end else begin
                        w_arm_we = 1'b1;
                        n_phase  = apd_pkg::PH_ARM1;
                    end
                end
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= apd_pkg::PH_IDLE;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_peak      <= '0;
            r_peak_time <= '0;
            r_last      <= '0;
            r_start     <= '0;
            r_count     <= '0;
        end else if (w_s2_fire) begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_sqsum     <= n_sqsum;
            r_peak      <= n_peak;
            r_peak_time <= n_peak_time;
            r_last      <= n_last;
            r_start     <= n_start;
            r_count     <= n_count;
        end
    end

    // arming store
    always_ff @(posedge i_clk) begin
        if (w_s2_fire && w_arm_we) begin
            r_arm_sample[w_arm_idx] <= r_s2_sample;
            r_arm_time[w_arm_idx]   <= r_s2_time;
            r_arm_sq[w_arm_idx]     <= r_s2_sq;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_fire && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && w_emit) begin
            r_out_duration  <= r_s2_time - r_start;
            r_out_sum       <= r_sum;
            r_out_sqsum     <= r_sqsum;
            r_out_peak      <= r_peak;
            r_out_peak_time <= r_peak_time;
            r_out_count     <= r_count;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.duration     = r_out_duration;
    assign o_result.level_sum    = r_out_sum;
    assign o_result.square_sum   = r_out_sqsum;
    assign o_result.peak_level   = r_out_peak;
    assign o_result.peak_time    = r_out_peak_time;
    assign o_result.sample_count = r_out_count;

    // ---------------- assertions ----------------
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> (r_v1 && r_v2 && r_out_valid))
        else $error("input stalled with room in the pipeline");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_phase == apd_pkg::PH_IDLE))
        else $error("result beat without return to idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == apd_pkg::PH_CAPTURE) |->
            (r_count >= apd_pkg::ARM_COUNT && r_count <= apd_pkg::MAX_CAPTURE))
        else $error("capture count out of range");

    a_sqsum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == apd_pkg::PH_CAPTURE) |-> (r_sqsum < apd_pkg::SQ_BOUND))
        else $error("square sum escaped rescale range");

endmodule

// File: verif/adc_pulse_detector_tb.sv
`timescale 1ns / 100ps
// testbench for adc_pulse_detector: directed and random sample streams, every
// result beat checked against an in-bench pulse predictor
// depends on apd_pkg, apd_sample_if, apd_result_if and the design

module adc_pulse_detector_tb;

    localparam int unsigned IDLE_MAX    = 12;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef logic [apd_pkg::SAMPLE_W-1:0] t_level;

    typedef struct packed {
        logic [apd_pkg::SAMPLE_W-1:0] sample;
        logic [apd_pkg::TIME_W-1:0]   timestamp;
    } t_sample_beat;

    typedef struct packed {
        logic [apd_pkg::TIME_W-1:0]   duration;
        logic [apd_pkg::SUM_W-1:0]    level_sum;
        logic [apd_pkg::SUM_W-1:0]    square_sum;
        logic [apd_pkg::SAMPLE_W-1:0] peak_level;
        logic [apd_pkg::TIME_W-1:0]   peak_time;
        logic [apd_pkg::COUNT_W-1:0]  sample_count;
    } t_pulse_summary;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [apd_pkg::PADDR_W-1:0] paddr;
    logic [apd_pkg::PDATA_W-1:0] pwdata;
    logic [apd_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    apd_sample_if sample_ch ();
    apd_result_if result_ch ();

    adc_pulse_detector dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register copy
    logic [apd_pkg::SAMPLE_W-1:0] cfg_baseline = apd_pkg::RST_BASELINE;
    logic [apd_pkg::SAMPLE_W-1:0] cfg_gap      = apd_pkg::RST_GAP;
    logic [apd_pkg::WINDOW_W-1:0] cfg_window   = apd_pkg::RST_WINDOW;
    logic [apd_pkg::QUIET_W-1:0]  cfg_quiet    = apd_pkg::RST_QUIET;

    // predictor state
    apd_pkg::t_phase              ph        = apd_pkg::PH_IDLE;
    logic [apd_pkg::SAMPLE_W-1:0] arm_lvl [0:3] = '{default: '0};
    logic [apd_pkg::TIME_W-1:0]   arm_ts  [0:3] = '{default: '0};
    logic [apd_pkg::SUM_W-1:0]    acc_sum   = '0;
    logic [apd_pkg::SUM_W-1:0]    acc_sq    = '0;
    logic [apd_pkg::SAMPLE_W-1:0] pk_lvl    = '0;
    logic [apd_pkg::TIME_W-1:0]   pk_ts     = '0;
    logic [apd_pkg::TIME_W-1:0]   strong_ts = '0;
    logic [apd_pkg::TIME_W-1:0]   start_ts  = '0;
    logic [apd_pkg::COUNT_W-1:0]  cap_cnt   = '0;

    t_sample_beat   sample_q [$];
    t_pulse_summary summary_q [$];
    t_sample_beat   cur_beat;

    int  beats_queued = 0;
    int  beats_taken  = 0;
    int  send_gap     = 0;
    int  recv_wait    = 0;
    int  hold_req     = 0;
    int  hold_done    = 0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;
    int  mismatches   = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;

    logic [apd_pkg::TIME_W-1:0] cur_t      = '0;
    logic [apd_pkg::TIME_W-1:0] gen_strong = '0;

    task automatic keep_first(input logic [apd_pkg::SAMPLE_W-1:0] s,
                              input logic [apd_pkg::TIME_W-1:0] t);
        arm_lvl[0] = s;
        arm_ts[0]  = t;
        ph         = apd_pkg::PH_ARM1;
    endtask

    task automatic predict_pulse(input t_sample_beat b);
        logic [apd_pkg::SAMPLE_W-1:0] s;
        logic [apd_pkg::TIME_W-1:0]   t;
        logic [apd_pkg::SAMPLE_W-1:0] dev;
        t_pulse_summary               res;
        int                           best;
        int                           k;
        s = b.sample;
        t = b.timestamp;
        if (ph == apd_pkg::PH_CAPTURE) begin
            if (s < cfg_gap && (t - strong_ts) > cfg_quiet) begin
                res.duration     = t - start_ts;
                res.level_sum    = acc_sum;
                res.square_sum   = acc_sq;
                res.peak_level   = pk_lvl;
                res.peak_time    = pk_ts;
                res.sample_count = cap_cnt;
                summary_q.push_back(res);
                ph      = apd_pkg::PH_IDLE;
                acc_sum = '0;
                acc_sq  = '0;
            end else begin
                if (s > cfg_gap) strong_ts = t;
                acc_sum = acc_sum + 32'(s);
                acc_sq  = acc_sq + 32'(s) * 32'(s);
                if (acc_sq > apd_pkg::SQ_LIMIT) acc_sq = acc_sq / 32'd10000;
                if (s > pk_lvl) begin
                    pk_lvl = s;
                    pk_ts  = t;
                end
                if (cap_cnt < apd_pkg::MAX_CAPTURE) cap_cnt = cap_cnt + 1'b1;
            end
        end else begin
            dev = (s > cfg_baseline) ? s - cfg_baseline : cfg_baseline - s;
            if (dev > cfg_gap) begin
                case (ph)
                    apd_pkg::PH_IDLE: begin
                        keep_first(s, t);
                    end
                    apd_pkg::PH_ARM1, apd_pkg::PH_ARM2: begin
                        if (t - arm_ts[0] < cfg_window) begin
                            arm_lvl[ph] = s;
                            arm_ts[ph]  = t;
                            ph = apd_pkg::t_phase'(ph + 3'd1);
                        end else begin
                            keep_first(s, t);
                        end
                    end
                    default: begin
                        if (t - arm_ts[1] < cfg_window) begin
                            arm_lvl[3] = s;
                            arm_ts[3]  = t;
                            acc_sum = '0;
                            acc_sq  = '0;
                            best    = 3;
                            // latest of equal maxima wins
                            for (k = 3; k >= 0; k--) begin
                                acc_sum = acc_sum + 32'(arm_lvl[k]);
                                acc_sq  = acc_sq + 32'(arm_lvl[k]) * 32'(arm_lvl[k]);
                                if (arm_lvl[k] > arm_lvl[best]) best = k;
                            end
                            pk_lvl    = arm_lvl[best];
                            pk_ts     = arm_ts[best];
                            start_ts  = arm_ts[3];
                            strong_ts = arm_ts[3];
                            cap_cnt   = apd_pkg::ARM_COUNT;
                            ph        = apd_pkg::PH_CAPTURE;
                        end else begin
                            keep_first(s, t);
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sample driver
    always @(posedge i_clk) begin : driver
        logic nxt_valid;
        if (!i_rst_n) begin
            sample_ch.valid     <= 1'b0;
            sample_ch.sample    <= '0;
            sample_ch.timestamp <= '0;
        end else begin
            nxt_valid = sample_ch.valid;
            if (sample_ch.valid && sample_ch.ready) begin
                predict_pulse(cur_beat);
                beats_taken++;
                nxt_valid = 1'b0;
                send_gap  = send_idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (sample_q.size() > 0) begin
                    cur_beat = sample_q.pop_front();
                    sample_ch.sample    <= cur_beat.sample;
                    sample_ch.timestamp <= cur_beat.timestamp;
                    nxt_valid = 1'b1;
                end
            end
            sample_ch.valid <= nxt_valid;
        end
    end

    // result monitor and ready control
    always @(posedge i_clk) begin : monitor
        t_pulse_summary want;
        logic           nxt_ready;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (summary_q.size() == 0) begin
                    $error("result beat with no pulse summary pending");
                    mismatches++;
                end else begin
                    want = summary_q.pop_front();
                    check_field("duration", want.duration, result_ch.duration);
                    check_field("level_sum", want.level_sum, result_ch.level_sum);
                    check_field("square_sum", want.square_sum, result_ch.square_sum);
                    check_field("peak_level", 32'(want.peak_level), 32'(result_ch.peak_level));
                    check_field("peak_time", want.peak_time, result_ch.peak_time);
                    check_field("sample_count", 32'(want.sample_count),
                                32'(result_ch.sample_count));
                end
                recv_wait = recv_idle_on ? $urandom_range(IDLE_MAX, 0) : 0;
            end
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            result_ch.ready <= nxt_ready;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic push_beat(input int unsigned s, input logic [apd_pkg::TIME_W-1:0] t);
        t_sample_beat b;
        b.sample    = t_level'(s);
        b.timestamp = t;
        sample_q.push_back(b);
        beats_queued++;
    endtask

    task automatic drain();
        while (beats_taken != beats_queued || summary_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(input apd_pkg::t_reg_idx idx,
                             input logic [apd_pkg::PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            apd_pkg::REG_BASELINE: cfg_baseline = val[apd_pkg::SAMPLE_W-1:0];
            apd_pkg::REG_GAP:      cfg_gap      = val[apd_pkg::SAMPLE_W-1:0];
            apd_pkg::REG_WINDOW:   cfg_window   = val[apd_pkg::WINDOW_W-1:0];
            default:               cfg_quiet    = val[apd_pkg::QUIET_W-1:0];
        endcase
    endtask

    // upper bits carry noise, the block keeps only the field width
    task automatic set_config(input int b, input int g, input int w, input int q);
        reg_write(apd_pkg::REG_BASELINE, ($urandom & 32'hFFFF_F000) | b);
        reg_write(apd_pkg::REG_GAP, ($urandom & 32'hFFFF_F000) | g);
        reg_write(apd_pkg::REG_WINDOW, ($urandom & 32'hFFFF_FF00) | w);
        reg_write(apd_pkg::REG_QUIET, ($urandom & 32'hFFFF_0000) | q);
        cur_t = $urandom;
    endtask

    function automatic int strong_level();
        int up_lo;
        int dn_hi;
        up_lo = int'(cfg_baseline) + int'(cfg_gap) + 1;
        dn_hi = int'(cfg_baseline) - int'(cfg_gap) - 1;
        if (up_lo <= 4095 && (dn_hi < 0 || $urandom_range(1, 0) == 1))
            return $urandom_range(4095, up_lo);
        else if (dn_hi >= 0)
            return $urandom_range(dn_hi, 0);
        return -1;
    endfunction

    task automatic noise(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(3, 0) == 0) cur_t = $urandom;
            else cur_t += $urandom_range(300, 0);
            push_beat($urandom_range(4095, 0), cur_t);
        end
    endtask

    // four close strong samples, n_cap capture samples, then a quiet end sample if the gap is nonzero
    task automatic pulse(input int n_cap);
        int                           lvl;
        int                           step;
        int                           k;
        logic [apd_pkg::SAMPLE_W-1:0] s;
        lvl = strong_level();
        if (lvl < 0) begin
            noise(1);
        end else begin
            step = (cfg_window > 0) ? (int'(cfg_window) - 1) / 3 : 0;
            for (k = 0; k < 4; k++) begin
                if (k > 0 && $urandom_range(2, 0) != 0) lvl = strong_level();
                push_beat(lvl, cur_t);
                gen_strong = cur_t;
                if (k < 3) cur_t += $urandom_range(step, 0);
            end
            for (k = 0; k < n_cap; k++) begin
                cur_t += $urandom_range(3, 0);
                case ($urandom_range(9, 0))
                    0:       s = cfg_gap;
                    1, 2:    s = t_level'($urandom_range(cfg_gap, 0));
                    default: s = (cfg_gap == 12'hFFF) ? cfg_gap :
                                 t_level'($urandom_range(4095, int'(cfg_gap) + 1));
                endcase
                if (s > cfg_gap) gen_strong = cur_t;
                push_beat(s, cur_t);
            end
            if (cfg_gap > 0) begin
                // weak sample right at the timeout does not end the pulse
                if ($urandom_range(1, 0) == 1)
                    push_beat($urandom_range(cfg_gap - 1, 0), gen_strong + cfg_quiet);
                cur_t = gen_strong + cfg_quiet + 1 + $urandom_range(20, 0);
                push_beat($urandom_range(cfg_gap - 1, 0), cur_t);
            end
        end
    endtask

    task automatic run_random(input int n_beats);
        int stop_at;
        int pick;
        stop_at = beats_queued + n_beats;
        while (beats_queued < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                pulse(($urandom_range(7, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(12, 0));
            end else if (pick < 80) begin
                // arming broken by a late strong sample
                if (strong_level() < 0) begin
                    noise(1);
                end else begin
                    repeat ($urandom_range(3, 1)) push_beat(strong_level(), cur_t);
                    cur_t += cfg_window + $urandom_range(50, 0);
                    pulse($urandom_range(8, 0));
                end
            end else begin
                noise($urandom_range(5, 1));
            end
        end
    endtask

    initial begin : stimulus
        int k;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: baseline 0, gap 55, window 10, quiet 1000
        push_beat(12'd0, 32'd0);
        push_beat(12'd55, 32'd1);
        push_beat(12'd56, 32'd100);
        push_beat(12'd300, 32'd105);
        push_beat(12'd4095, 32'd120);
        push_beat(12'd4095, 32'd121);
        push_beat(12'd100, 32'd129);
        push_beat(12'd4095, 32'd130);
        push_beat(12'd55, 32'd500);
        push_beat(12'd0, 32'd1100);
        push_beat(12'd4095, 32'd1101);
        push_beat(12'd55, 32'd2102);
        push_beat(12'd54, 32'd2103);
        // arming across timestamp wrap
        push_beat(12'd3000, 32'hFFFF_FFFE);
        push_beat(12'd3000, 32'hFFFF_FFFF);
        push_beat(12'd3001, 32'd0);
        push_beat(12'd2000, 32'd3);
        push_beat(12'd4000, 32'd5);
        push_beat(12'd0, 32'd1006);
        // fourth arming sample too far from the second
        push_beat(12'd60, 32'd5000);
        push_beat(12'd60, 32'd5001);
        push_beat(12'd60, 32'd5009);
        push_beat(12'd60, 32'd5011);
        push_beat(12'd60, 32'd5012);
        push_beat(12'd60, 32'd5013);
        push_beat(12'd60, 32'd5014);
        push_beat(12'd0, 32'd6100);
        drain();

        set_config(2048, 100, 255, 0);
        run_random(150);
        drain();

        // zero gap: capture never ends here
        set_config(4095, 0, 1, 65535);
        run_random(60);
        drain();

        set_config(0, 4095, 128, 500);
        noise(40);
        drain();

        // zero window: arming never passes one sample
        set_config(1000, 200, 0, 50);
        run_random(40);
        drain();

        for (k = 0; k < 4; k++) begin
            send_idle_on = (k != 1);
            recv_idle_on = (k != 2);
            set_config($urandom_range(4095, 0), $urandom_range(400, 1),
                       $urandom_range(255, 1), $urandom_range(300, 0));
            run_random(150);
            drain();
        end

        // long receiver stall while samples keep coming
        send_idle_on = 1'b0;
        recv_idle_on = 1'b1;
        set_config(500, 60, 40, 20);
        hold_req++;
        run_random(100);
        drain();

        // long pulse
        send_idle_on = 1'b1;
        set_config(0, 55, 10, 1000);
        pulse(50);
        drain();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
